// File: hdl/tbd_pkg.sv
// ----------------------------------------------------------------------------
// tbd_pkg
// Shared types and constants of the two-button debouncer with auto-repeat.
// ----------------------------------------------------------------------------
package tbd_pkg;

  localparam int DEBOUNCE_WIDTH = 16;
  localparam int CFG_LONG_W     = 16;
  localparam int CFG_SHORT_W    = 8;
  localparam int CMP_W          = (DEBOUNCE_WIDTH > CFG_LONG_W) ? DEBOUNCE_WIDTH : CFG_LONG_W;
  localparam int CFG_INDEX_W    = 3;
  localparam int IN_DATA_W      = 16;
  localparam int OUT_DATA_W     = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_DEBOUNCE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_DEBOUNCE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_WAIT_TICKS     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_REPEAT_TICKS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEATS_PER_SPEEDUP = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_STEP         = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_REPEAT_TICKS    = 3'd6;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_CANCEL  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PRESSED  = 3'd1,
    EV_HOLD     = 3'd2,
    EV_LONG     = 3'd3,
    EV_REPEAT   = 3'd4,
    EV_RELEASED = 3'd5
  } event_t;

  typedef struct packed {
    logic [CFG_LONG_W-1:0]  press_debounce;
    logic [CFG_LONG_W-1:0]  release_debounce;
    logic [CFG_SHORT_W-1:0] long_wait_ticks;
    logic [CFG_SHORT_W-1:0] first_repeat_ticks;
    logic [CFG_SHORT_W-1:0] repeats_per_speedup;
    logic [CFG_SHORT_W-1:0] repeat_step;
    logic [CFG_SHORT_W-1:0] min_repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic sample;
    logic force_wait;
  } dbn_ctrl_t;

  typedef struct packed {
    logic rel;
    logic pressed;
  } dbn_stat_t;

  typedef struct packed {
    logic   kind_b;
    logic   kind_a;
    event_t event_res;
  } result_t;

endpackage

// File: hdl/tbd_debounce.sv
// ----------------------------------------------------------------------------
// tbd_debounce
// Debounce state of one active-low button: mode and saturating sample counter.
// ----------------------------------------------------------------------------
module tbd_debounce (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic                       level,
  input  tbd_pkg::cfg_t              cfg,
  input  tbd_pkg::dbn_ctrl_t         ctrl,
  output tbd_pkg::dbn_stat_t         stat
);
  import tbd_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PRESSED = 2'd1,
    MODE_WAIT    = 2'd2
  } mode_t;

  localparam logic [DEBOUNCE_WIDTH-1:0] CNT_MAX = '1;

  mode_t                     mode_r;
  mode_t                     mode_nxt;
  mode_t                     mode_dbn;
  logic [DEBOUNCE_WIDTH-1:0] count_r;
  logic [DEBOUNCE_WIDTH-1:0] count_nxt;
  logic [DEBOUNCE_WIDTH-1:0] count_dbn;
  logic [DEBOUNCE_WIDTH-1:0] count_inc;
  logic [CFG_LONG_W-1:0]     thr;
  logic                      hit;
  logic                      rel;

  always_comb begin
    count_inc = (count_r == CNT_MAX) ? count_r : count_r + 1'b1;
    thr       = level ? cfg.release_debounce : cfg.press_debounce;
    hit       = (CMP_W'(count_inc) >= CMP_W'(thr)) || (count_inc == CNT_MAX);
    mode_dbn  = mode_r;
    count_dbn = count_r;
    rel       = 1'b0;
    if (ctrl.sample) begin
      if (level) begin
        if (mode_r != MODE_IDLE) begin
          if (hit) begin
            rel       = (mode_r == MODE_PRESSED);
            mode_dbn  = MODE_IDLE;
            count_dbn = '0;
          end else begin
            count_dbn = count_inc;
          end
        end else begin
          count_dbn = '0;
        end
      end else begin
        if (mode_r == MODE_IDLE) begin
          if (hit) begin
            mode_dbn  = MODE_PRESSED;
            count_dbn = '0;
          end else begin
            count_dbn = count_inc;
          end
        end else begin
          count_dbn = '0;
        end
      end
    end
    stat.rel     = rel;
    stat.pressed = (mode_dbn == MODE_PRESSED);
    mode_nxt     = (ctrl.force_wait && mode_dbn == MODE_PRESSED) ? MODE_WAIT : mode_dbn;
    count_nxt    = count_dbn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      count_r <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: hdl/tbd_event.sv
// ----------------------------------------------------------------------------
// tbd_event
// Combination tracking, long press timing and accelerating auto-repeat.
// ----------------------------------------------------------------------------
module tbd_event (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  tbd_pkg::cmd_t                cmd,
  input  logic [7:0]                   tick,
  input  tbd_pkg::cfg_t                cfg,
  input  tbd_pkg::dbn_stat_t           stat_a,
  input  tbd_pkg::dbn_stat_t           stat_b,
  output tbd_pkg::dbn_ctrl_t           ctrl_a,
  output tbd_pkg::dbn_ctrl_t           ctrl_b,
  output tbd_pkg::result_t             res
);
  import tbd_pkg::*;

  logic [1:0] last_r, last_nxt;
  logic [7:0] wait_left_r, wait_left_nxt;
  logic [7:0] period_r, period_nxt;
  logic       repeating_r, repeating_nxt;
  logic [7:0] repeats_left_r, repeats_left_nxt;
  logic [7:0] seen_tick_r, seen_tick_nxt;
  logic [1:0] kind;
  logic [1:0] kind_out;
  logic [7:0] shrunk;
  event_t     ev;
  logic       sample;

  always_comb begin
    last_nxt         = last_r;
    wait_left_nxt    = wait_left_r;
    period_nxt       = period_r;
    repeating_nxt    = repeating_r;
    repeats_left_nxt = repeats_left_r;
    seen_tick_nxt    = seen_tick_r;
    ev               = EV_NONE;
    kind_out         = 2'b00;
    sample           = 1'b0;
    ctrl_a.force_wait = 1'b0;
    ctrl_b.force_wait = 1'b0;
    kind   = {stat_b.pressed, stat_a.pressed};
    shrunk = (period_r > cfg.repeat_step) ? period_r - cfg.repeat_step : 8'd0;
    if (shrunk < cfg.min_repeat_ticks) begin
      shrunk = cfg.min_repeat_ticks;
    end
    case (cmd)
      CMD_SAMPLE: begin
        sample = 1'b1;
        if (stat_a.rel || stat_b.rel) begin
          ev                = EV_RELEASED;
          kind_out          = last_r;
          ctrl_a.force_wait = last_r[0];
          ctrl_b.force_wait = last_r[1];
          last_nxt          = 2'b00;
        end else if (kind == 2'b00) begin
          last_nxt = 2'b00;
        end else if (kind != last_r) begin
          ev            = EV_PRESSED;
          kind_out      = kind;
          last_nxt      = kind;
          repeating_nxt = 1'b0;
          wait_left_nxt = cfg.long_wait_ticks;
        end else if (seen_tick_r == tick) begin
          ev       = EV_HOLD;
          kind_out = kind;
        end else begin
          kind_out      = kind;
          seen_tick_nxt = tick;
          if (wait_left_r != 8'd0) begin
            ev            = EV_HOLD;
            wait_left_nxt = wait_left_r - 8'd1;
          end else if (!repeating_r) begin
            ev               = EV_LONG;
            repeating_nxt    = 1'b1;
            period_nxt       = cfg.first_repeat_ticks;
            wait_left_nxt    = cfg.first_repeat_ticks;
            repeats_left_nxt = cfg.repeats_per_speedup;
          end else begin
            ev = EV_REPEAT;
            if (repeats_left_r != 8'd0) begin
              repeats_left_nxt = repeats_left_r - 8'd1;
              wait_left_nxt    = period_r;
            end else begin
              period_nxt       = shrunk;
              repeats_left_nxt = cfg.repeats_per_speedup;
              wait_left_nxt    = shrunk;
            end
          end
        end
      end
      CMD_CANCEL: begin
        ctrl_a.force_wait = 1'b1;
        ctrl_b.force_wait = 1'b1;
      end
      CMD_RESTART: begin
        if (last_r != 2'b00 && repeating_r) begin
          period_nxt       = cfg.first_repeat_ticks;
          wait_left_nxt    = cfg.first_repeat_ticks;
          repeats_left_nxt = cfg.repeats_per_speedup;
        end
      end
      default: begin
      end
    endcase
    ctrl_a.sample = sample;
    ctrl_b.sample = sample;
    res.event_res = ev;
    res.kind_a    = kind_out[0];
    res.kind_b    = kind_out[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r         <= 2'b00;
      wait_left_r    <= 8'd0;
      period_r       <= 8'd0;
      repeating_r    <= 1'b0;
      repeats_left_r <= 8'd0;
      seen_tick_r    <= 8'd0;
    end else if (fire) begin
      last_r         <= last_nxt;
      wait_left_r    <= wait_left_nxt;
      period_r       <= period_nxt;
      repeating_r    <= repeating_nxt;
      repeats_left_r <= repeats_left_nxt;
      seen_tick_r    <= seen_tick_nxt;
    end
  end

endmodule

// File: hdl/two_button_debounce_autorepeat.sv
// ----------------------------------------------------------------------------
// two_button_debounce_autorepeat
// Debounces two active-low buttons and reports press, hold, long press,
// accelerating auto-repeat and release of the pressed combination.
//
// The in_ channel takes one word per polling step: a command (sample pins,
// cancel held buttons, restart repeat acceleration), both raw pin levels and
// the current value of a free-running slow tick counter. Every input word
// gives exactly one result word on the out_ channel: an event code and the
// two buttons of the reported combination. Registers are to be written
// through the cfg_ port only while no word is in flight; the block does not
// enforce this. A word goes through an input register, one pass of debounce
// and event logic, and a result register, which drives out_tvalid. One word
// per cycle is sustained while out_tready stays high; the limit is the
// single state update per word in the debounce and event logic.
// Synchronous reset clears all button state and loads the register defaults.
// When the receiver holds out_tready low, the result stays in its register,
// one more word is held in the input register, and in_tready then drops.
// ----------------------------------------------------------------------------
module two_button_debounce_autorepeat (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // command[1:0], pin_a[2], pin_b[3], tick_count[11:4], zero fill
  input  logic [tbd_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // event_res[2:0], kind_a[3], kind_b[4], zero fill
  output logic [tbd_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [tbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tbd_pkg::CFG_LONG_W-1:0]    cfg_data
);
  import tbd_pkg::*;

  cfg_t       cfg_r;
  logic       in_valid_r;
  cmd_t       in_cmd_r;
  logic       in_pin_a_r;
  logic       in_pin_b_r;
  logic [7:0] in_tick_r;
  logic       out_valid_r;
  result_t    out_res_r;
  logic       fire;
  dbn_ctrl_t  ctrl_a;
  dbn_ctrl_t  ctrl_b;
  dbn_stat_t  stat_a;
  dbn_stat_t  stat_b;
  result_t    res;

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_debounce      <= 16'd20;
      cfg_r.release_debounce    <= 16'd20;
      cfg_r.long_wait_ticks     <= 8'd50;
      cfg_r.first_repeat_ticks  <= 8'd20;
      cfg_r.repeats_per_speedup <= 8'd4;
      cfg_r.repeat_step         <= 8'd2;
      cfg_r.min_repeat_ticks    <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESS_DEBOUNCE:      cfg_r.press_debounce      <= cfg_data;
        REG_RELEASE_DEBOUNCE:    cfg_r.release_debounce    <= cfg_data;
        REG_LONG_WAIT_TICKS:     cfg_r.long_wait_ticks     <= cfg_data[7:0];
        REG_FIRST_REPEAT_TICKS:  cfg_r.first_repeat_ticks  <= cfg_data[7:0];
        REG_REPEATS_PER_SPEEDUP: cfg_r.repeats_per_speedup <= cfg_data[7:0];
        REG_REPEAT_STEP:         cfg_r.repeat_step         <= cfg_data[7:0];
        REG_MIN_REPEAT_TICKS:    cfg_r.min_repeat_ticks    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r   <= cmd_t'(in_tdata[1:0]);
      in_pin_a_r <= in_tdata[2];
      in_pin_b_r <= in_tdata[3];
      in_tick_r  <= in_tdata[11:4];
    end
  end

  tbd_debounce u_dbn_a (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .level (in_pin_a_r),
    .cfg   (cfg_r),
    .ctrl  (ctrl_a),
    .stat  (stat_a)
  );

  tbd_debounce u_dbn_b (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .level (in_pin_b_r),
    .cfg   (cfg_r),
    .ctrl  (ctrl_b),
    .stat  (stat_b)
  );

  tbd_event u_event (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .cmd    (in_cmd_r),
    .tick   (in_tick_r),
    .cfg    (cfg_r),
    .stat_a (stat_a),
    .stat_b (stat_b),
    .ctrl_a (ctrl_a),
    .ctrl_b (ctrl_b),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.kind_b, out_res_r.kind_a, out_res_r.event_res};

endmodule
